[rtl/srr_pkg.sv]
`timescale 1ns / 1ps

package srr_pkg;

    // Fixed port field widths
    localparam int SEQ_W = 16;
    localparam int PAY_W = 64;

    // Parameter defaults
    localparam int DEF_WINDOW       = 8;
    localparam int DEF_SEQ_BITS     = 16;
    localparam int DEF_PAYLOAD_BITS = 64;

    // Result kinds
    localparam logic KIND_ACK     = 1'b0;
    localparam logic KIND_DELIVER = 1'b1;

    typedef struct packed {
        logic [SEQ_W-1:0] seq_num;
        logic             checksum_good;
        logic [PAY_W-1:0] payload_word;
    } t_req;

    typedef struct packed {
        logic             result_kind;
        logic [SEQ_W-1:0] ack_number;
        logic [PAY_W-1:0] delivered_payload;
        logic             last_result;
    } t_res;

    // Shared adder operations
    typedef enum logic [1:0] {
        OP_SUB_SEQ  = 2'd0,   // (a - b) mod 2^SEQ_BITS
        OP_ADD_SEQ  = 2'd1,   // (a + b) mod 2^SEQ_BITS
        OP_ADD_RING = 2'd2    // (a + b) mod WINDOW, both below WINDOW
    } t_alu_op;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_AHEAD  = 8'b0000_0010,
        S_CLASS  = 8'b0000_0100,
        S_BEHIND = 8'b0000_1000,
        S_STORE  = 8'b0001_0000,
        S_RD     = 8'b0010_0000,
        S_DEL    = 8'b0100_0000,
        S_ADV    = 8'b1000_0000
    } t_state;

endpackage

[rtl/selective_repeat_receiver.sv]
`timescale 1ns / 1ps
// Selective-repeat receiver: one request at a time, one shared adder under a small sequencer.
// Corrupted request: taken and dropped, busy never rises. Good request: busy through AHEAD,
// CLASS and STORE (or BEHIND), any acknowledgement strobing in the cycle after that state; a
// base hit adds RD (a RAM read), then per delivery DEL and ADV step head and base by the adder.
// Results cannot be stalled. Synchronous active-low reset: base 0, head 0, no slot held.

module selective_repeat_receiver #(
    parameter int WINDOW       = srr_pkg::DEF_WINDOW,
    parameter int SEQ_BITS     = srr_pkg::DEF_SEQ_BITS,
    parameter int PAYLOAD_BITS = srr_pkg::DEF_PAYLOAD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  srr_pkg::t_req i_req,
    output logic          busy,
    output logic          o_res_strobe,
    output srr_pkg::t_res o_res
);

    // Slot index width and shared datapath width (wide enough for the sequence
    // space, for WINDOW itself and for a ring sum below 2*WINDOW).
    localparam int HW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WCW = $clog2(WINDOW + 1) + 1;
    localparam int DW  = (SEQ_BITS > WCW) ? SEQ_BITS : WCW;

    localparam logic [DW-1:0] WIN = DW'(WINDOW);
    localparam logic [DW-1:0] ONE = DW'(1);

    srr_pkg::t_state r_state, n_state;

    logic [SEQ_BITS-1:0]     r_base, n_base;
    logic [HW-1:0]           r_head, n_head;
    logic [WINDOW-1:0]       r_held, n_held;
    logic [SEQ_BITS-1:0]     r_seq, n_seq;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [DW-1:0]           r_diff, n_diff;   // ahead, later behind
    logic [HW-1:0]           r_slot, n_slot;
    logic                    r_more, n_more;   // another held slot follows
    logic                    r_strobe, n_strobe;
    srr_pkg::t_res           r_res, n_res;

    // Shared adder
    srr_pkg::t_alu_op alu_op;
    logic [DW-1:0]    alu_a, alu_b, alu_res;

    srr_alu #(
        .WINDOW   (WINDOW),
        .SEQ_BITS (SEQ_BITS),
        .DW       (DW)
    ) u_alu (
        .i_op  (alu_op),
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Payload store, one entry per window slot
    logic                    ram_we, ram_re;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    srr_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_pay),
        .i_re    (ram_re),
        .i_raddr (r_head),
        .o_rdata (ram_rdata)
    );

    logic [HW-1:0] nxt_head;
    assign nxt_head = alu_res[HW-1:0];

    assign busy         = (r_state != srr_pkg::S_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    always_comb begin
        n_state  = r_state;
        n_base   = r_base;
        n_head   = r_head;
        n_held   = r_held;
        n_seq    = r_seq;
        n_pay    = r_pay;
        n_diff   = r_diff;
        n_slot   = r_slot;
        n_more   = r_more;
        n_strobe = 1'b0;
        n_res    = r_res;
        alu_op   = srr_pkg::OP_SUB_SEQ;
        alu_a    = DW'(r_seq);
        alu_b    = DW'(r_base);
        ram_we   = 1'b0;
        ram_re   = 1'b0;

        case (r_state)
            srr_pkg::S_IDLE: begin
                if (start) begin
                    n_seq = SEQ_BITS'(i_req.seq_num);
                    n_pay = PAYLOAD_BITS'(i_req.payload_word);
                    // corrupted requests vanish here
                    if (i_req.checksum_good) begin
                        n_state = srr_pkg::S_AHEAD;
                    end
                end
            end

            srr_pkg::S_AHEAD: begin
                // ahead = seq - base
                n_diff  = alu_res;
                n_state = srr_pkg::S_CLASS;
            end

            srr_pkg::S_CLASS: begin
                if (r_diff < WIN) begin
                    // in window: slot = (head + ahead) mod WINDOW
                    alu_op  = srr_pkg::OP_ADD_RING;
                    alu_a   = DW'(r_head);
                    alu_b   = r_diff;
                    n_slot  = alu_res[HW-1:0];
                    n_state = srr_pkg::S_STORE;
                end else begin
                    // behind = base - seq
                    alu_a   = DW'(r_base);
                    alu_b   = DW'(r_seq);
                    n_diff  = alu_res;
                    n_state = srr_pkg::S_BEHIND;
                end
            end

            srr_pkg::S_BEHIND: begin
                // previous window: re-acknowledge only
                if (r_diff >= ONE && r_diff <= WIN) begin
                    n_strobe                = 1'b1;
                    n_res.result_kind       = srr_pkg::KIND_ACK;
                    n_res.ack_number        = srr_pkg::SEQ_W'(r_seq);
                    n_res.delivered_payload = '0;
                    n_res.last_result       = 1'b1;
                end
                n_state = srr_pkg::S_IDLE;
            end

            srr_pkg::S_STORE: begin
                // duplicates keep the first payload
                if (!r_held[r_slot]) begin
                    ram_we         = 1'b1;
                    n_held[r_slot] = 1'b1;
                end
                n_strobe                = 1'b1;
                n_res.result_kind       = srr_pkg::KIND_ACK;
                n_res.ack_number        = srr_pkg::SEQ_W'(r_seq);
                n_res.delivered_payload = '0;
                // base hit: the slot just stored drains at once
                n_res.last_result       = (r_diff != '0);
                n_state = (r_diff == '0) ? srr_pkg::S_RD : srr_pkg::S_IDLE;
            end

            srr_pkg::S_RD: begin
                ram_re  = 1'b1;
                n_state = srr_pkg::S_DEL;
            end

            srr_pkg::S_DEL: begin
                alu_op         = srr_pkg::OP_ADD_RING;
                alu_a          = DW'(r_head);
                alu_b          = ONE;
                n_held[r_head] = 1'b0;
                n_head         = nxt_head;
                // stop at a gap; a one-slot ring wraps onto the slot being freed
                n_more         = r_held[nxt_head] && (nxt_head != r_head);
                n_strobe                = 1'b1;
                n_res.result_kind       = srr_pkg::KIND_DELIVER;
                n_res.ack_number        = '0;
                n_res.delivered_payload = srr_pkg::PAY_W'(ram_rdata);
                n_res.last_result       = !n_more;
                n_state = srr_pkg::S_ADV;
            end

            srr_pkg::S_ADV: begin
                alu_op  = srr_pkg::OP_ADD_SEQ;
                alu_a   = DW'(r_base);
                alu_b   = ONE;
                n_base  = alu_res[SEQ_BITS-1:0];
                ram_re  = r_more;
                n_state = r_more ? srr_pkg::S_DEL : srr_pkg::S_IDLE;
            end

            default: begin
                n_state = srr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= srr_pkg::S_IDLE;
            r_base   <= '0;
            r_head   <= '0;
            r_held   <= '0;
            r_more   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_base   <= n_base;
            r_head   <= n_head;
            r_held   <= n_held;
            r_more   <= n_more;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq  <= n_seq;
        r_pay  <= n_pay;
        r_diff <= n_diff;
        r_slot <= n_slot;
        r_res  <= n_res;
    end

endmodule

[rtl/srr_ram.sv]
`timescale 1ns / 1ps

module srr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/srr_alu.sv]
`timescale 1ns / 1ps

module srr_alu #(
    parameter int WINDOW   = srr_pkg::DEF_WINDOW,
    parameter int SEQ_BITS = srr_pkg::DEF_SEQ_BITS,
    parameter int DW       = 17
) (
    input  srr_pkg::t_alu_op i_op,
    input  logic [DW-1:0]    i_a,
    input  logic [DW-1:0]    i_b,
    output logic [DW-1:0]    o_res
);

    localparam logic [DW-1:0] SEQ_MASK = DW'((65'(1) << SEQ_BITS) - 65'(1));
    localparam logic [DW-1:0] WIN      = DW'(WINDOW);

    logic [DW-1:0] sum;
    logic [DW-1:0] dif;

    assign sum = i_a + i_b;
    assign dif = i_a - i_b;

    always_comb begin
        case (i_op)
            srr_pkg::OP_SUB_SEQ:  o_res = dif & SEQ_MASK;
            srr_pkg::OP_ADD_SEQ:  o_res = sum & SEQ_MASK;
            srr_pkg::OP_ADD_RING: o_res = (sum >= WIN) ? (sum - WIN) : sum;
            default:              o_res = sum;
        endcase
    end

endmodule

[tb/srr_result_checker.sv]
`timescale 1ns / 1ps

// Watches the request and result channels of the selective-repeat receiver,
// predicts acknowledgements and in-order deliveries, compares field by field.
module srr_result_checker #(
    parameter int WINDOW       = srr_pkg::DEF_WINDOW,
    parameter int SEQ_BITS     = srr_pkg::DEF_SEQ_BITS,
    parameter int PAYLOAD_BITS = srr_pkg::DEF_PAYLOAD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  srr_pkg::t_req i_req,
    input  logic          i_res_strobe,
    input  srr_pkg::t_res i_res,
    output int            o_mismatches,
    output int            o_outstanding
);
    import srr_pkg::*;

    localparam logic [63:0] SEQ_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - SEQ_BITS);
    localparam logic [63:0] PAY_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - PAYLOAD_BITS);

    // predictor state
    logic [63:0] window_base;
    logic [63:0] ring_head;
    bit          slot_held    [WINDOW];
    logic [63:0] slot_payload [WINDOW];

    t_res expected_results [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    task automatic predict_acks_and_deliveries(input t_req r);
        logic [63:0] seq;
        logic [63:0] ahead;
        logic [63:0] behind;
        logic [63:0] slot;
        t_res        burst [WINDOW+1];
        int          n;
        int          moved;
        seq    = r.seq_num & SEQ_MASK;
        ahead  = (seq - window_base) & SEQ_MASK;
        behind = (window_base - seq) & SEQ_MASK;
        n      = 0;
        moved  = 0;
        if (!r.checksum_good)
            return;
        if (ahead < WINDOW) begin
            slot = (ring_head + ahead) % WINDOW;
            // a duplicate keeps the payload already held
            if (!slot_held[slot]) begin
                slot_payload[slot] = r.payload_word & PAY_MASK;
                slot_held[slot]    = 1'b1;
            end
            burst[n] = '{KIND_ACK, seq[15:0], 64'd0, 1'b0};
            n++;
            if (ahead == 0) begin
                while (moved < WINDOW && slot_held[ring_head]) begin
                    burst[n] = '{KIND_DELIVER, 16'd0, slot_payload[ring_head], 1'b0};
                    n++;
                    slot_held[ring_head] = 1'b0;
                    ring_head   = (ring_head + 1) % WINDOW;
                    window_base = (window_base + 1) & SEQ_MASK;
                    moved++;
                end
            end
        end else if (behind >= 1 && behind <= WINDOW) begin
            burst[n] = '{KIND_ACK, seq[15:0], 64'd0, 1'b0};
            n++;
        end else begin
            return;
        end
        burst[n-1].last_result = 1'b1;
        for (int k = 0; k < n; k++)
            expected_results.push_back(burst[k]);
    endtask

    task automatic compare_result(input t_res got);
        t_res want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d ack %0d payload %h last %0d",
                   got.result_kind, got.ack_number, got.delivered_payload, got.last_result);
            o_mismatches++;
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind) begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            o_mismatches++;
        end
        if (got.ack_number !== want.ack_number) begin
            $error("ack_number: expected %0d, got %0d", want.ack_number, got.ack_number);
            o_mismatches++;
        end
        if (got.delivered_payload !== want.delivered_payload) begin
            $error("delivered_payload: expected %h, got %h",
                   want.delivered_payload, got.delivered_payload);
            o_mismatches++;
        end
        if (got.last_result !== want.last_result) begin
            $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_base = '0;
            ring_head   = '0;
            for (int k = 0; k < WINDOW; k++)
                slot_held[k] = 1'b0;
            expected_results.delete();
        end else begin
            // results first: an old request may finish on the edge a new one is taken
            if (i_res_strobe)
                compare_result(i_res);
            if (i_start && !i_busy)
                predict_acks_and_deliveries(i_req);
        end
        o_outstanding = expected_results.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import srr_pkg::*;

    // Generous ceiling for a full run.
    localparam int CYCLE_LIMIT = 50_000;
    // Margin for the longest request, a base hit draining the whole window, before the verdict.
    localparam int DRAIN_CYCLES = 30;
    localparam int RANDOM_ITEMS = 140;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start   = 1'b0;
    t_req  i_req   = '0;
    logic  busy;
    logic  o_res_strobe;
    t_res  o_res;

    int    mismatches;
    int    outstanding;
    int    cycles = 0;
    int    issued = 0;
    bit    no_idle = 1'b0;
    logic [15:0] snd_base;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    selective_repeat_receiver u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_req        (i_req),
        .busy         (busy),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    srr_result_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_res_strobe  (o_res_strobe),
        .i_res         (o_res),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // Present one request and hold it until the block takes it (start high, busy low).
    // Called at a rising edge; returns at the edge where the request went in, so the
    // next request can follow back to back with a single assignment to start.
    task automatic issue(input logic [15:0] seq, input logic good, input logic [63:0] pay);
        t_req r;
        if (!no_idle && $urandom_range(99) < 22) begin
            start <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
        r.seq_num       = seq;
        r.checksum_good = good;
        r.payload_word  = pay;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        issued++;
    endtask

    // One window's worth from the sender: the eight numbers from snd_base in shuffled
    // order, salted with corrupted copies, stale retransmissions from the previous
    // window, stray noise, duplicates and losses that get resent at the end.
    task automatic send_window(input int rand_start);
        int    order [8];
        int    lost [$];
        int    j;
        int    tmp;
        logic [15:0] seq;
        for (int i = 0; i < 8; i++)
            order[i] = i;
        for (int i = 7; i > 0; i--) begin
            j        = $urandom_range(i, 0);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < 8; i++) begin
            // long stretch with no sender gaps in the middle of the random part
            no_idle = (issued - rand_start >= 60) && (issued - rand_start < 100);
            seq = snd_base + 16'(order[i]);
            if ($urandom_range(99) < 10)
                issue(seq, 1'b0, rnd64());
            if ($urandom_range(99) < 8)
                issue(snd_base - 16'($urandom_range(8, 1)), 1'b1, rnd64());
            if ($urandom_range(99) < 5)
                issue(16'($urandom_range(65535, 0)), 1'($urandom_range(1, 0)), rnd64());
            if ($urandom_range(99) < 12) begin
                lost.push_back(order[i]);
            end else begin
                issue(seq, 1'b1, rnd64());
                if ($urandom_range(99) < 10)
                    issue(seq, 1'b1, rnd64());
            end
        end
        foreach (lost[k])
            issue(snd_base + 16'(lost[k]), 1'b1, rnd64());
        snd_base = snd_base + 16'd8;
    endtask

    initial begin
        int rand_start;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed: base starts at 0 ----
        issue(16'd0, 1'b0, rnd64());                   // corrupted: dropped
        issue(16'd65535, 1'b1, rnd64());               // one behind, across the wrap: re-ack
        issue(16'd65528, 1'b1, rnd64());               // full window behind: re-ack
        issue(16'd65527, 1'b1, rnd64());               // just beyond previous window: dropped
        issue(16'd8, 1'b1, rnd64());                   // just beyond the window: dropped
        issue(16'h8000, 1'b1, rnd64());                // far away: dropped
        issue(16'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);   // top of window, stored
        issue(16'd7, 1'b1, 64'd0);                     // duplicate: re-ack, payload kept
        for (int s = 6; s >= 1; s--)
            issue(16'(s), 1'b1, rnd64());
        issue(16'd0, 1'b0, rnd64());                   // corrupted base
        issue(16'd0, 1'b1, 64'd0);                     // base: ack plus eight deliveries
        issue(16'd0, 1'b1, rnd64());                   // now a full window behind
        issue(16'd7, 1'b1, rnd64());                   // one behind
        issue(16'd9, 1'b1, rnd64());
        issue(16'd8, 1'b1, rnd64());                   // base: ack plus two deliveries

        // ---- random windows from the current base ----
        snd_base   = 16'd10;
        rand_start = issued;
        while (issued - rand_start < RANDOM_ITEMS)
            send_window(rand_start);
        no_idle = 1'b0;

        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[filelist.f]
rtl/srr_pkg.sv
rtl/srr_ram.sv
rtl/srr_alu.sv
rtl/selective_repeat_receiver.sv
tb/srr_result_checker.sv
tb/testbench.sv
